[sv/wdg_pkg.sv]
// Shared types and constants for the two-stage compare watchdog.
// Depends on nothing; used by every module of the block.
package wdg_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  // Frame select
  localparam logic FRAME_CTRL = 1'b0;

  // Register offsets within a frame
  localparam logic [11:0] OFS_STATUS = 12'h000;
  localparam logic [11:0] OFS_OFF_LO = 12'h008;
  localparam logic [11:0] OFS_OFF_HI = 12'h00C;
  localparam logic [11:0] OFS_CMP_LO = 12'h010;
  localparam logic [11:0] OFS_CMP_HI = 12'h014;
  localparam logic [11:0] OFS_IDENT  = 12'hFCC;

  // Configuration register indexes
  localparam logic CFG_ARCH_VERSION = 1'b0;

  localparam int OFFSET_W = 48;
  localparam int COUNT_W  = 64;

  // One request
  typedef struct packed {
    cmd_t         cmd;
    logic         frame;
    logic [11:0]  byte_offset;
    logic [31:0]  write_data;
    logic [63:0]  count_now;
  } item_t;

  // One result
  typedef struct packed {
    logic [31:0] read_data;
    logic        stage_one;
    logic        stage_two;
  } result_t;

endpackage

[sv/wdg_cfg.sv]
// APB-style configuration port holding the arch_version register.
// Depends on wdg_pkg.
module wdg_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        arch_version
);
  import wdg_pkg::*;

  logic wr_en;
  logic rd_hit;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == CFG_ARCH_VERSION);
  assign rd_hit = (paddr[2] == CFG_ARCH_VERSION);

  // Register write; resets to the 48-bit offset layout
  always_ff @(posedge clk) begin
    if (rst) begin
      arch_version <= 1'b1;
    end else if (wr_en) begin
      arch_version <= pwdata[0];
    end
  end

  // Read back
  assign prdata = rd_hit ? {31'd0, arch_version} : 32'd0;

endmodule

[sv/wdg_core.sv]
// Watchdog state and single-pass update for one request.
// Depends on wdg_pkg.
module wdg_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             arch_version,
  input  logic             fire,
  input  wdg_pkg::item_t   item,
  output wdg_pkg::result_t result
);
  import wdg_pkg::*;

  logic                enabled, enabled_next;
  logic                first_stage_flag, first_stage_flag_next;
  logic                second_stage_flag, second_stage_flag_next;
  logic [OFFSET_W-1:0] offset_value, offset_value_next;
  logic [COUNT_W-1:0]  compare_value, compare_value_next;
  logic [OFFSET_W-1:0] eff_offset;
  logic [OFFSET_W-1:0] eff_offset_cur;
  logic [COUNT_W-1:0]  reload_value;
  logic                expired;
  logic                do_refresh;
  logic                do_reload;
  logic [31:0]         read_data;

  // Offset seen by sums uses the value after any offset write
  assign eff_offset = arch_version ? offset_value_next
                                   : {16'd0, offset_value_next[31:0]};
  assign eff_offset_cur = arch_version ? offset_value : {16'd0, offset_value[31:0]};
  assign reload_value = item.count_now + {16'd0, eff_offset};
  assign expired = enabled && (item.count_now >= compare_value);

  // Register writes and tick decode
  always_comb begin
    enabled_next       = enabled;
    offset_value_next  = offset_value;
    compare_value_next = compare_value;
    do_refresh         = 1'b0;
    do_reload          = 1'b0;
    case (item.cmd)
      CMD_TICK: begin
        do_reload = expired;
      end
      CMD_WRITE: begin
        if (item.frame != FRAME_CTRL) begin
          do_refresh = (item.byte_offset == OFS_STATUS);
        end else begin
          case (item.byte_offset)
            OFS_STATUS: begin
              enabled_next = item.write_data[0];
              do_refresh   = 1'b1;
            end
            OFS_OFF_LO: begin
              offset_value_next = arch_version ? {offset_value[47:32], item.write_data}
                                               : {16'd0, item.write_data};
              do_refresh = 1'b1;
            end
            OFS_OFF_HI: begin
              if (arch_version) begin
                offset_value_next = {item.write_data[15:0], offset_value[31:0]};
                do_refresh        = 1'b1;
              end
            end
            OFS_CMP_LO: compare_value_next = {compare_value[63:32], item.write_data};
            OFS_CMP_HI: compare_value_next = {item.write_data, compare_value[31:0]};
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    if (do_refresh || do_reload) begin
      compare_value_next = reload_value;
    end
  end

  // Stage flags
  always_comb begin
    first_stage_flag_next  = first_stage_flag;
    second_stage_flag_next = second_stage_flag;
    if (do_refresh) begin
      first_stage_flag_next  = 1'b0;
      second_stage_flag_next = 1'b0;
    end else if (do_reload) begin
      if (!first_stage_flag) begin
        first_stage_flag_next = 1'b1;
      end else begin
        second_stage_flag_next = 1'b1;
      end
    end
  end

  // Read mux, on the state before the request
  always_comb begin
    read_data = 32'd0;
    if (item.cmd == CMD_READ) begin
      if (item.byte_offset == OFS_IDENT) begin
        read_data = {15'd0, arch_version, 16'd0};
      end else if (item.frame == FRAME_CTRL) begin
        case (item.byte_offset)
          OFS_STATUS: read_data = {29'd0, second_stage_flag, first_stage_flag, enabled};
          OFS_OFF_LO: read_data = eff_offset_cur[31:0];
          OFS_OFF_HI: read_data = {16'd0, eff_offset_cur[47:32]};
          OFS_CMP_LO: read_data = compare_value[31:0];
          OFS_CMP_HI: read_data = compare_value[63:32];
          default:    read_data = 32'd0;
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled           <= 1'b0;
      first_stage_flag  <= 1'b0;
      second_stage_flag <= 1'b0;
      offset_value      <= '0;
      compare_value     <= '0;
    end else if (fire) begin
      enabled           <= enabled_next;
      first_stage_flag  <= first_stage_flag_next;
      second_stage_flag <= second_stage_flag_next;
      offset_value      <= offset_value_next;
      compare_value     <= compare_value_next;
    end
  end

  assign result.read_data = read_data;
  assign result.stage_one = first_stage_flag_next;
  assign result.stage_two = second_stage_flag_next;

endmodule

[sv/two_stage_compare_watchdog.sv]
// Two-stage compare watchdog: input register, single-pass update, result register.
// A request waits in the input register and moves on into the result register and onto m_axis
// when the result register is free; a stalled result holds the request back.
// Throughput: one request per cycle unless m_axis stalls; 64-bit add and compare set the path.
// Reset clears enable, stage flags, offset and compare; arch_version returns to 1.
// Depends on wdg_pkg, wdg_cfg and wdg_core.
module two_stage_compare_watchdog (
  input  logic         clk,
  input  logic         rst,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,  // byte_offset[11:0], write_data[43:12], count_now[107:44]
  input  logic [2:0]   s_axis_tuser,  // cmd[1:0], frame[2]
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,  // read_data[31:0], stage_one[32], stage_two[33]
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import wdg_pkg::*;

  logic    arch_version;
  logic    in_valid;
  item_t   in_item;
  logic    advance;
  result_t core_result;
  result_t out_result;

  wdg_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .arch_version (arch_version)
  );

  // Move the held request into the result register when that is free
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.cmd         <= cmd_t'(s_axis_tuser[1:0]);
      in_item.frame       <= s_axis_tuser[2];
      in_item.byte_offset <= s_axis_tdata[11:0];
      in_item.write_data  <= s_axis_tdata[43:12];
      in_item.count_now   <= s_axis_tdata[107:44];
    end
  end

  wdg_core u_core (
    .clk          (clk),
    .rst          (rst),
    .arch_version (arch_version),
    .fire         (advance),
    .item         (in_item),
    .result       (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign m_axis_tdata = {6'd0, out_result.stage_two, out_result.stage_one,
                         out_result.read_data};

endmodule
